/* sv/inclusive_date_span_days_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the date span block.
// Each macro takes a label, a property expression and a message string.
// ----------------------------------------------------------------------------
`ifndef INCLUSIVE_DATE_SPAN_DAYS_ASSERT_SVH
`define INCLUSIVE_DATE_SPAN_DAYS_ASSERT_SVH

`ifndef SYNTHESIS
`define IDS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define IDS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define IDS_ASSERT(label, prop, msg)
`define IDS_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* sv/ids_pkg.sv */
// ----------------------------------------------------------------------------
// ids_pkg
// Widths, constants, types and helper functions of the date span block.
// ----------------------------------------------------------------------------
package ids_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CountW = 22;
  localparam int unsigned DoyW   = 9;
  localparam int unsigned Q100W  = 8;
  localparam int unsigned LeapW  = 12;
  localparam int unsigned OrdW   = 23;
  localparam int unsigned DiffW  = OrdW + 1;

  localparam int unsigned RecipW     = 13;
  localparam int unsigned RecipShift = 19;
  localparam int unsigned ProdW      = YearW + RecipW;
  localparam int unsigned HundW      = Q100W + 7;

  localparam logic [RecipW-1:0] Recip100 = 13'd5243;
  localparam logic [YearW-1:0]  YearMax  = 14'd9999;
  localparam logic [MonW-1:0]   MonthMax = 4'd12;
  localparam logic [MonW-1:0]   MonthMar = 4'd3;
  localparam logic [OrdW-1:0]   DaysYear = 23'd365;
  localparam logic [HundW-1:0]  Hundred  = 15'd100;

  typedef struct packed {
    logic [YearW-1:0] year;
    logic [YearW-1:0] year_m1;
    logic [Q100W-1:0] q100_m1;
    logic [Q100W-1:0] q100_y;
    logic [DoyW-1:0]  doy_base;
    logic             past_feb;
  } s1_date_t;

  typedef struct packed {
    logic [OrdW-1:0]  days_years;
    logic [LeapW-1:0] leaps;
    logic [DoyW-1:0]  doy;
  } s2_date_t;

  function automatic logic [DoyW-1:0] month_start(input logic [MonW-1:0] m);
    logic [DoyW-1:0] v;
    unique case (m)
      4'd1:    v = 9'd0;
      4'd2:    v = 9'd31;
      4'd3:    v = 9'd59;
      4'd4:    v = 9'd90;
      4'd5:    v = 9'd120;
      4'd6:    v = 9'd151;
      4'd7:    v = 9'd181;
      4'd8:    v = 9'd212;
      4'd9:    v = 9'd243;
      4'd10:   v = 9'd273;
      4'd11:   v = 9'd304;
      4'd12:   v = 9'd334;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [Q100W-1:0] div100(input logic [YearW-1:0] y);
    logic [ProdW-1:0] p;
    p = ProdW'(y) * ProdW'(Recip100);
    return p[RecipShift +: Q100W];
  endfunction

  function automatic logic field_ok(input logic [DayW-1:0] d, input logic [MonW-1:0] m,
                                    input logic [YearW-1:0] y);
    return (d != '0) && (m != '0) && (m <= MonthMax) && (y != '0) && (y <= YearMax);
  endfunction

  function automatic s1_date_t date_s1(input logic [DayW-1:0] d, input logic [MonW-1:0] m,
                                       input logic [YearW-1:0] y);
    s1_date_t r;
    r.year     = y;
    r.year_m1  = y - YearW'(1);
    r.q100_m1  = div100(r.year_m1);
    r.q100_y   = div100(y);
    r.doy_base = month_start(m) + DoyW'(d);
    r.past_feb = (m >= MonthMar);
    return r;
  endfunction

  function automatic s2_date_t date_s2(input s1_date_t a);
    s2_date_t        r;
    logic [HundW-1:0] cent;
    logic            by100;
    logic            leap;
    cent  = HundW'(a.q100_y) * Hundred;
    by100 = (cent == HundW'(a.year));
    leap  = (a.year[1:0] == 2'b00) && (!by100 || (a.q100_y[1:0] == 2'b00));
    r.days_years = OrdW'(a.year_m1) * DaysYear;
    r.leaps      = LeapW'(a.year_m1 >> 2) - LeapW'(a.q100_m1) + LeapW'(a.q100_m1 >> 2);
    r.doy        = a.doy_base + DoyW'(leap && a.past_feb);
    return r;
  endfunction

endpackage

/* sv/ids_if.sv */
// ----------------------------------------------------------------------------
// ids_if
// Valid/ready channels of the date span block: date pair in, day count out.
// ----------------------------------------------------------------------------
interface ids_in_if;
  logic                     valid;
  logic                     ready;
  logic [ids_pkg::DayW-1:0]  start_day;
  logic [ids_pkg::MonW-1:0]  start_month;
  logic [ids_pkg::YearW-1:0] start_year;
  logic [ids_pkg::DayW-1:0]  end_day;
  logic [ids_pkg::MonW-1:0]  end_month;
  logic [ids_pkg::YearW-1:0] end_year;

  modport source (output valid, start_day, start_month, start_year,
                  end_day, end_month, end_year, input ready);
  modport sink   (input valid, start_day, start_month, start_year,
                  end_day, end_month, end_year, output ready);
endinterface

interface ids_out_if;
  logic                      valid;
  logic                      ready;
  logic [ids_pkg::CountW-1:0] day_count;
  logic                      order_error;

  modport source (output valid, day_count, order_error, input ready);
  modport sink   (input valid, day_count, order_error, output ready);
endinterface

/* sv/inclusive_date_span_days.sv */
// ----------------------------------------------------------------------------
// inclusive_date_span_days: inclusive Gregorian day count between two dates.
// Pipeline: the result passes the s1, s2, s3 and output registers to reach out_o.
// Throughput: one transaction per cycle; a stall on out_o holds every stage.
// Reset clears the stage valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
`include "inclusive_date_span_days_assert.svh"

module inclusive_date_span_days (
  input  logic      clk_i,
  input  logic      rst_ni,
  ids_in_if.sink    in_i,
  ids_out_if.source out_o
);

  logic en;

  logic                     s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic                     s1_err_q, s2_err_q, s3_err_q, out_err_q;
  ids_pkg::s1_date_t        s1_a_q, s1_b_q;
  ids_pkg::s2_date_t        s2_a_q, s2_b_q;
  logic [ids_pkg::OrdW-1:0] s3_ord_a_q, s3_ord_b_q;
  logic [ids_pkg::CountW-1:0] out_count_q;

  logic                       s1_err_d;
  logic [ids_pkg::DiffW-1:0]  diff;
  logic [ids_pkg::CountW-1:0] out_count_d;

  assign en       = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  always_comb begin
    s1_err_d = !ids_pkg::field_ok(in_i.start_day, in_i.start_month, in_i.start_year) ||
               !ids_pkg::field_ok(in_i.end_day, in_i.end_month, in_i.end_year) ||
               ({in_i.end_year, in_i.end_month, in_i.end_day} <=
                {in_i.start_year, in_i.start_month, in_i.start_day});
  end

  always_comb begin
    diff = {1'b0, s3_ord_b_q} + ids_pkg::DiffW'(1) - {1'b0, s3_ord_a_q};
    if (s3_err_q || diff[ids_pkg::DiffW-1]) begin
      out_count_d = '0;
    end else begin
      out_count_d = diff[ids_pkg::CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= in_i.valid;
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_err_q    <= s1_err_d;
      s1_a_q      <= ids_pkg::date_s1(in_i.start_day, in_i.start_month, in_i.start_year);
      s1_b_q      <= ids_pkg::date_s1(in_i.end_day, in_i.end_month, in_i.end_year);
      s2_err_q    <= s1_err_q;
      s2_a_q      <= ids_pkg::date_s2(s1_a_q);
      s2_b_q      <= ids_pkg::date_s2(s1_b_q);
      s3_err_q    <= s2_err_q;
      s3_ord_a_q  <= s2_a_q.days_years + ids_pkg::OrdW'(s2_a_q.leaps) +
                     ids_pkg::OrdW'(s2_a_q.doy);
      s3_ord_b_q  <= s2_b_q.days_years + ids_pkg::OrdW'(s2_b_q.leaps) +
                     ids_pkg::OrdW'(s2_b_q.doy);
      out_err_q   <= s3_err_q;
      out_count_q <= out_count_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.day_count   = out_count_q;
  assign out_o.order_error = out_err_q;

  `IDS_ASSERT(a_err_zero, (out_valid_q && out_err_q) |-> (out_count_q == '0), "error with count")
  `IDS_ASSERT(a_stall_holds, !en |=> ($stable({s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q})), "pipeline moved during stall")
  `IDS_ASSERT(a_out_from_s3, (out_valid_q && !$past(out_valid_q)) |-> $past(s3_valid_q), "result without source stage")
  `IDS_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !(s1_valid_q || s2_valid_q || s3_valid_q || out_valid_q), "valid bits set in reset")

endmodule
